// File: src/vt4x4_pkg.sv
package vt4x4_pkg;

   // matrix dimension actually used (2 to 4)
   localparam int unsigned DIM        = 4;
   // fixed field widths
   localparam int unsigned NUM_COMP   = 4;
   localparam int unsigned COORD_W    = 32;
   localparam int unsigned COEF_W     = 16;
   localparam int unsigned ROW_W      = COEF_W * NUM_COMP;
   localparam int unsigned FRAC_SHIFT = 12;
   localparam int unsigned CSR_IDX_W  = 4;

   // derived datapath widths
   localparam int unsigned PROD_W  = COEF_W + COORD_W;
   localparam int unsigned SHIFT_W = PROD_W - FRAC_SHIFT;
   localparam int unsigned SUM_W   = SHIFT_W + $clog2(DIM);

   localparam logic [COEF_W-1:0] ONE_Q412 = COEF_W'(1) << FRAC_SHIFT;

   typedef logic signed [COORD_W-1:0]  coord_type;
   typedef logic signed [COEF_W-1:0]   coef_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [SUM_W-1:0]    sum_type;
   typedef logic [ROW_W-1:0]           row_type;
   typedef logic [CSR_IDX_W-1:0]       csr_idx_type;
   typedef coord_type [NUM_COMP-1:0]   point_type;

   // one lane's finished component
   typedef struct packed {
      coord_type value;
      logic      sat;
   } lane_res_type;

   typedef struct packed {
      coord_type out_x;
      coord_type out_y;
      coord_type out_z;
      coord_type out_w;
      logic      saturated;
   } rsp_payload_type;

   // identity matrix row: one at entry i
   function automatic row_type identity_row(int unsigned i);
      identity_row = ROW_W'(ONE_Q412) << (COEF_W * i);
   endfunction

endpackage

// File: src/vt4x4_if.sv
interface vt4x4_req_if;
   logic                  valid;
   logic                  ready;
   vt4x4_pkg::coord_type  in_x;
   vt4x4_pkg::coord_type  in_y;
   vt4x4_pkg::coord_type  in_z;
   vt4x4_pkg::coord_type  in_w;

   modport source (output valid, output in_x, output in_y, output in_z, output in_w,
                   input ready);
   modport sink   (input valid, input in_x, input in_y, input in_z, input in_w,
                   output ready);
endinterface

interface vt4x4_rsp_if;
   logic                  valid;
   logic                  ready;
   vt4x4_pkg::coord_type  out_x;
   vt4x4_pkg::coord_type  out_y;
   vt4x4_pkg::coord_type  out_z;
   vt4x4_pkg::coord_type  out_w;
   logic                  saturated;

   modport source (output valid, output out_x, output out_y, output out_z, output out_w,
                   output saturated, input ready);
   modport sink   (input valid, input out_x, input out_y, input out_z, input out_w,
                   input saturated, output ready);
endinterface

interface vt4x4_csr_if;
   logic                    valid;
   logic                    ready;
   vt4x4_pkg::csr_idx_type  index;
   vt4x4_pkg::row_type      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/vertex_transform_4x4.sv
// channel  | dir | payload                                   | handshake
// req_if   | in  | in_x, in_y, in_z, in_w (signed q16.16)    | valid / ready
// rsp_if   | out | out_x..out_w (signed q16.16), saturated   | valid / ready
// csr_if   | in  | index (row number), data (four q4.12)     | valid / ready
//
// one word accepted per cycle while the output is not stalled; each word passes
// multiply, shift-and-sum, then clip and merge into the output register
// a stall on rsp_if holds the whole three-stage pipe; req_if.ready follows
// rsp_if.ready whenever the output register is full
// reset (synchronous) empties the pipe and loads the identity matrix
// csr writes are registered into the row registers and are taken whenever reset
// is low; a word accepted on the same edge still multiplies with the old rows
module vertex_transform_4x4 (
   input  logic       clock,
   input  logic       reset,
   vt4x4_req_if.sink  req_if,
   vt4x4_rsp_if.source rsp_if,
   vt4x4_csr_if.sink  csr_if
);

   // matrix rows, one register per lane
   vt4x4_pkg::row_type rows_ff [vt4x4_pkg::DIM];
   vt4x4_pkg::row_type rows_in [vt4x4_pkg::DIM];

   // valid bits for the multiply, sum and output stages
   logic mul_vld_ff, mul_vld_in;
   logic sum_vld_ff, sum_vld_in;
   logic out_vld_ff, out_vld_in;

   logic                       pipe_en;
   logic                       csr_wr;
   vt4x4_pkg::point_type       pt;
   vt4x4_pkg::lane_res_type    lane_res [vt4x4_pkg::DIM];
   vt4x4_pkg::rsp_payload_type payload;

   // whole pipe advances unless the output word is stuck
   assign pipe_en = !out_vld_ff || rsp_if.ready;

   assign req_if.ready = pipe_en && !reset;
   assign csr_if.ready = !reset;
   assign csr_wr       = csr_if.valid && csr_if.ready;

   // point components in lane order
   assign pt[0] = req_if.in_x;
   assign pt[1] = req_if.in_y;
   assign pt[2] = req_if.in_z;
   assign pt[3] = req_if.in_w;

   // row writes; indexes past the last row are dropped
   always_comb begin
      for (int i = 0; i < vt4x4_pkg::DIM; i++) begin
         if (csr_wr && csr_if.index == vt4x4_pkg::CSR_IDX_W'(i)) begin
            rows_in[i] = csr_if.data;
         end else begin
            rows_in[i] = rows_ff[i];
         end
      end
   end

   always_comb begin
      if (pipe_en) begin
         mul_vld_in = req_if.valid && req_if.ready;
         sum_vld_in = mul_vld_ff;
         out_vld_in = sum_vld_ff;
      end else begin
         mul_vld_in = mul_vld_ff;
         sum_vld_in = sum_vld_ff;
         out_vld_in = out_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < vt4x4_pkg::DIM; i++) begin
            rows_ff[i] <= vt4x4_pkg::identity_row(i);
         end
         mul_vld_ff <= 1'b0;
         sum_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         rows_ff    <= rows_in;
         mul_vld_ff <= mul_vld_in;
         sum_vld_ff <= sum_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // one lane per matrix row
   for (genvar g = 0; g < vt4x4_pkg::DIM; g++) begin : g_lane
      vt4x4_lane u_lane (
         .clock (clock),
         .en    (pipe_en),
         .row   (rows_ff[g]),
         .pt    (pt),
         .res   (lane_res[g])
      );
   end

   // gather lane results and the common clip flag
   vt4x4_merge u_merge (
      .clock (clock),
      .en    (pipe_en),
      .res   (lane_res),
      .out   (payload)
   );

   assign rsp_if.valid     = out_vld_ff;
   assign rsp_if.out_x     = payload.out_x;
   assign rsp_if.out_y     = payload.out_y;
   assign rsp_if.out_z     = payload.out_z;
   assign rsp_if.out_w     = payload.out_w;
   assign rsp_if.saturated = payload.saturated;

endmodule

// File: src/vt4x4_lane.sv
module vt4x4_lane (
   input  logic                    clock,
   input  logic                    en,
   input  vt4x4_pkg::row_type      row,
   input  vt4x4_pkg::point_type    pt,
   output vt4x4_pkg::lane_res_type res
);

   vt4x4_pkg::prod_type prod_ff [vt4x4_pkg::DIM];
   vt4x4_pkg::prod_type prod_in [vt4x4_pkg::DIM];
   vt4x4_pkg::sum_type  sum_ff;
   vt4x4_pkg::sum_type  sum_in;
   vt4x4_pkg::coef_type coef    [vt4x4_pkg::DIM];
   logic                clip_hi;
   logic                clip_lo;

   // stage 1: one product per column
   always_comb begin
      for (int j = 0; j < vt4x4_pkg::DIM; j++) begin
         coef[j]    = vt4x4_pkg::coef_type'(row[vt4x4_pkg::COEF_W*j +: vt4x4_pkg::COEF_W]);
         prod_in[j] = en ? coef[j] * pt[j] : prod_ff[j];
      end
   end

   // stage 2: floor shift and sum
   always_comb begin
      sum_in = '0;
      for (int j = 0; j < vt4x4_pkg::DIM; j++) begin
         sum_in = sum_in + vt4x4_pkg::SUM_W'(prod_ff[j] >>> vt4x4_pkg::FRAC_SHIFT);
      end
      if (!en) begin
         sum_in = sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
   end

   // clip when the sign bit of a 32-bit value and the bits above it disagree
   assign clip_hi = !sum_ff[vt4x4_pkg::SUM_W-1] &&
                    (|sum_ff[vt4x4_pkg::SUM_W-2:vt4x4_pkg::COORD_W-1]);
   assign clip_lo = sum_ff[vt4x4_pkg::SUM_W-1] &&
                    !(&sum_ff[vt4x4_pkg::SUM_W-2:vt4x4_pkg::COORD_W-1]);

   always_comb begin
      res.sat = clip_hi || clip_lo;
      if (clip_hi) begin
         res.value = {1'b0, {(vt4x4_pkg::COORD_W-1){1'b1}}};
      end else if (clip_lo) begin
         res.value = {1'b1, {(vt4x4_pkg::COORD_W-1){1'b0}}};
      end else begin
         res.value = vt4x4_pkg::coord_type'(sum_ff);
      end
   end

endmodule

// File: src/vt4x4_merge.sv
module vt4x4_merge (
   input  logic                       clock,
   input  logic                       en,
   input  vt4x4_pkg::lane_res_type    res [vt4x4_pkg::DIM],
   output vt4x4_pkg::rsp_payload_type out
);

   vt4x4_pkg::rsp_payload_type out_ff;
   vt4x4_pkg::rsp_payload_type out_in;
   vt4x4_pkg::point_type       comp;
   logic                       any_sat;

   // unused components stay zero
   always_comb begin
      comp    = '0;
      any_sat = 1'b0;
      for (int i = 0; i < vt4x4_pkg::DIM; i++) begin
         comp[i] = res[i].value;
         any_sat = any_sat | res[i].sat;
      end
   end

   always_comb begin
      if (en) begin
         out_in.out_x     = comp[0];
         out_in.out_y     = comp[1];
         out_in.out_z     = comp[2];
         out_in.out_w     = comp[3];
         out_in.saturated = any_sat;
      end else begin
         out_in = out_ff;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign out = out_ff;

endmodule

// File: src/vt4x4_chk.sv
module vt4x4_chk (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input vt4x4_pkg::coord_type rsp_out_x,
   input vt4x4_pkg::coord_type rsp_out_y,
   input vt4x4_pkg::coord_type rsp_out_z,
   input vt4x4_pkg::coord_type rsp_out_w,
   input logic                 rsp_saturated
);

   localparam vt4x4_pkg::coord_type CMAX = {1'b0, {(vt4x4_pkg::COORD_W-1){1'b1}}};
   localparam vt4x4_pkg::coord_type CMIN = {1'b1, {(vt4x4_pkg::COORD_W-1){1'b0}}};

   // word taken with output draining reaches the output register
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready ##1 rsp_ready ##1 rsp_ready) |=> rsp_valid)
      else $error("accepted word did not reach output");

   // a clipped result shows at least one component at a limit
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         (rsp_out_x == CMAX || rsp_out_x == CMIN || rsp_out_y == CMAX ||
          rsp_out_y == CMIN || rsp_out_z == CMAX || rsp_out_z == CMIN ||
          rsp_out_w == CMAX || rsp_out_w == CMIN))
      else $error("saturated set with no component clipped");

   // a full output with a stalled sink blocks new input
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input taken while output stalled");

   // stalled output word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_out_x) && $stable(rsp_out_y) &&
          $stable(rsp_out_z) && $stable(rsp_out_w) && $stable(rsp_saturated)))
      else $error("stalled output word changed");

endmodule

bind vertex_transform_4x4 vt4x4_chk u_chk (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_out_x     (rsp_if.out_x),
   .rsp_out_y     (rsp_if.out_y),
   .rsp_out_z     (rsp_if.out_z),
   .rsp_out_w     (rsp_if.out_w),
   .rsp_saturated (rsp_if.saturated)
);

// File: dv/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // register indexes on the csr channel; anything from 4 up is unmapped
   localparam vt4x4_pkg::csr_idx_type ROW0_IDX         = 4'd0;
   localparam vt4x4_pkg::csr_idx_type ROW1_IDX         = 4'd1;
   localparam vt4x4_pkg::csr_idx_type ROW2_IDX         = 4'd2;
   localparam vt4x4_pkg::csr_idx_type ROW3_IDX         = 4'd3;
   localparam vt4x4_pkg::csr_idx_type FIRST_UNUSED_IDX = 4'd4;
   localparam vt4x4_pkg::csr_idx_type LAST_UNUSED_IDX  = 4'd15;

   localparam vt4x4_pkg::coord_type COORD_MAX = 32'sh7FFF_FFFF;
   localparam vt4x4_pkg::coord_type COORD_MIN = 32'sh8000_0000;
   localparam vt4x4_pkg::coef_type  COEF_MAX  = 16'sh7FFF;
   localparam vt4x4_pkg::coef_type  COEF_MIN  = 16'sh8000;
   localparam vt4x4_pkg::coef_type  COEF_ONE  = 16'sh1000;
   localparam vt4x4_pkg::coef_type  COEF_HALF = 16'sh0800;
   localparam vt4x4_pkg::coef_type  COEF_MONE = -16'sh1000;

   localparam longint SUM_MAX = 64'sd2147483647;
   localparam longint SUM_MIN = -64'sd2147483648;

   // three stages between request and result
   localparam int PIPE_LATENCY = 3;
   localparam int PHASES       = 17;
   localparam int PHASE_WORDS  = 100;

   logic clock = 1'b0;
   logic reset;

   vt4x4_req_if req_bus ();
   vt4x4_rsp_if rsp_bus ();
   vt4x4_csr_if csr_bus ();

   vertex_transform_4x4 uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // our own copy of the matrix, kept in step with every accepted csr word
   vt4x4_pkg::row_type matrix_rows [vt4x4_pkg::NUM_COMP];

   // transformed points still owed by the block, oldest first
   vt4x4_pkg::rsp_payload_type expected_points[$];

   int  error_count = 0;
   // when set, neither side inserts idle cycles
   bit  steady_flow = 1'b0;

   always #1 clock = ~clock;

   // run-away guard
   initial begin
      #400_000;
      $display("*** FAILED ***");
      $finish;
   end

   // ------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------

   // matrix times point: floor-shifted q4.12 x q16.16 products, exact sum,
   // then clip each component to 32 bits
   function automatic vt4x4_pkg::rsp_payload_type transform_point(
      vt4x4_pkg::coord_type px, vt4x4_pkg::coord_type py,
      vt4x4_pkg::coord_type pz, vt4x4_pkg::coord_type pw);
      vt4x4_pkg::coord_type       pt   [vt4x4_pkg::NUM_COMP];
      vt4x4_pkg::coord_type       comp [vt4x4_pkg::NUM_COMP];
      vt4x4_pkg::coef_type        coef;
      longint                     acc;
      longint                     prod;
      vt4x4_pkg::rsp_payload_type res;
      pt = '{px, py, pz, pw};
      res.saturated = 1'b0;
      for (int i = 0; i < vt4x4_pkg::NUM_COMP; i++) begin
         acc = 0;
         // rows at or above DIM give zero
         if (i < vt4x4_pkg::DIM) begin
            for (int j = 0; j < vt4x4_pkg::DIM; j++) begin
               coef = matrix_rows[i][vt4x4_pkg::COEF_W*j +: vt4x4_pkg::COEF_W];
               prod = longint'(coef) * longint'(pt[j]);
               // arithmetic shift rounds toward minus infinity
               acc += prod >>> vt4x4_pkg::FRAC_SHIFT;
            end
            if (acc > SUM_MAX) begin
               acc = SUM_MAX;
               res.saturated = 1'b1;
            end else if (acc < SUM_MIN) begin
               acc = SUM_MIN;
               res.saturated = 1'b1;
            end
         end
         comp[i] = vt4x4_pkg::coord_type'(acc);
      end
      res.out_x = comp[0];
      res.out_y = comp[1];
      res.out_z = comp[2];
      res.out_w = comp[3];
      return res;
   endfunction

   function automatic vt4x4_pkg::row_type pack_row(vt4x4_pkg::coef_type e0,
                                                   vt4x4_pkg::coef_type e1,
                                                   vt4x4_pkg::coef_type e2,
                                                   vt4x4_pkg::coef_type e3);
      return {e3, e2, e1, e0};
   endfunction

   // ------------------------------------------------------------------
   // random values, biased toward the corners of q4.12 and q16.16
   // ------------------------------------------------------------------

   function automatic vt4x4_pkg::coef_type rand_coef();
      case ($urandom_range(0, 7))
         0, 1:    return vt4x4_pkg::coef_type'($urandom);
         2:       return vt4x4_pkg::coef_type'(int'($urandom_range(0, 8192)) - 4096);
         3:       return COEF_MAX;
         4:       return COEF_MIN;
         5:       return '0;
         6:       return COEF_ONE;
         default: return COEF_MONE;
      endcase
   endfunction

   function automatic vt4x4_pkg::coord_type rand_coord();
      case ($urandom_range(0, 7))
         0, 1, 2: return vt4x4_pkg::coord_type'($urandom);
         3:       return vt4x4_pkg::coord_type'(int'($urandom_range(0, 2097152)) - 1048576);
         4:       return COORD_MAX;
         5:       return COORD_MIN;
         6:       return vt4x4_pkg::coord_type'(int'($urandom_range(0, 8)) - 4);
         default: return vt4x4_pkg::coord_type'(int'($urandom_range(0, 268435456))
                                                - 134217728);
      endcase
   endfunction

   function automatic vt4x4_pkg::row_type rand_row();
      return pack_row(rand_coef(), rand_coef(), rand_coef(), rand_coef());
   endfunction

   // ------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(string what);
      $display("%0t mismatch: %s", $realtime, what);
      error_count++;
   endtask

   task automatic check_field(string name, logic [vt4x4_pkg::COORD_W-1:0] got,
                              logic [vt4x4_pkg::COORD_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h want %h", name, got, want));
   endtask

   // every accepted result word is held against the oldest prediction
   always @(posedge clock) begin
      vt4x4_pkg::rsp_payload_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_points.size() == 0) begin
            report_mismatch("result word with nothing outstanding");
         end else begin
            want = expected_points.pop_front();
            check_field("out_x", rsp_bus.out_x, want.out_x);
            check_field("out_y", rsp_bus.out_y, want.out_y);
            check_field("out_z", rsp_bus.out_z, want.out_z);
            check_field("out_w", rsp_bus.out_w, want.out_w);
            if (rsp_bus.saturated !== want.saturated)
               report_mismatch($sformatf("saturated got %b want %b",
                                         rsp_bus.saturated, want.saturated));
         end
      end
   end

   // result side back-pressure: ready may drop for a random stall before each word
   initial begin
      int unsigned stall;
      rsp_bus.ready = 1'b0;
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, 3);
         @(negedge clock);
         if (stall != 0) begin
            rsp_bus.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1 || reset);
      end
   end

   // ------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------

   // one point word; valid stays up on return so back-to-back words keep it high
   task automatic send_point(vt4x4_pkg::coord_type px, vt4x4_pkg::coord_type py,
                             vt4x4_pkg::coord_type pz, vt4x4_pkg::coord_type pw);
      int unsigned gap;
      gap = steady_flow ? 0 : $urandom_range(0, 3);
      @(negedge clock);
      if (gap != 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.in_x  = px;
      req_bus.in_y  = py;
      req_bus.in_z  = pz;
      req_bus.in_w  = pw;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      expected_points.push_back(transform_point(px, py, pz, pw));
   endtask

   task automatic send_random_point();
      send_point(rand_coord(), rand_coord(), rand_coord(), rand_coord());
   endtask

   // stop sending and wait for every outstanding result
   task automatic drain_results();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
   endtask

   // pipe fully empty, so matrix writes are safe
   task automatic settle();
      drain_results();
      repeat (PIPE_LATENCY + 1) @(posedge clock);
   endtask

   task automatic write_row(vt4x4_pkg::csr_idx_type idx, vt4x4_pkg::row_type value);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      // unmapped indexes are dropped by the block
      if (idx <= ROW3_IDX)
         matrix_rows[idx[1:0]] = value;
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic load_matrix(vt4x4_pkg::row_type r0, vt4x4_pkg::row_type r1,
                              vt4x4_pkg::row_type r2, vt4x4_pkg::row_type r3);
      settle();
      write_row(ROW0_IDX, r0);
      write_row(ROW1_IDX, r1);
      write_row(ROW2_IDX, r2);
      write_row(ROW3_IDX, r3);
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // identity after reset: every point comes back unchanged
   task automatic test_reset_identity();
      send_point(COORD_MAX, COORD_MIN, '0, -32'sd1);
      send_point(COORD_MIN, COORD_MAX, -32'sd1, '0);
      send_point(32'sd1, -32'sd1, 32'sh5555_5555, 32'shAAAA_AAAA);
   endtask

   // largest and most negative coefficients against extreme points
   task automatic test_extreme_matrix();
      load_matrix(pack_row(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX),
                  pack_row(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN),
                  pack_row(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN),
                  pack_row('0, '0, '0, '0));
      send_point(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
      send_point(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
      send_point('0, '0, '0, '0);
      send_point(COORD_MAX, COORD_MIN, 32'sd4096, -32'sd4096);
   endtask

   // floor rounding of negative products and fractional coefficients
   task automatic test_floor_rounding();
      load_matrix(pack_row(16'sd1, '0, '0, '0),
                  pack_row('0, -16'sd1, '0, '0),
                  pack_row(COEF_HALF, COEF_HALF, COEF_HALF, COEF_HALF),
                  pack_row(COEF_MIN, '0, '0, COEF_ONE));
      send_point(-32'sd1, -32'sd1, -32'sd1, -32'sd1);
      send_point(32'sd1, 32'sd1, 32'sd1, 32'sd1);
      send_point(-32'sd4097, 32'sd4097, 32'sd3, -32'sd3);
      send_point(32'sd4095, -32'sd4095, -32'sd8191, 32'sd8191);
   endtask

   // sums that land exactly on a limit versus one step past it
   task automatic test_saturation_edges();
      load_matrix(pack_row(COEF_ONE, COEF_ONE, '0, '0),
                  pack_row(COEF_ONE, COEF_ONE, '0, '0),
                  pack_row('0, '0, COEF_ONE, COEF_ONE),
                  pack_row('0, '0, COEF_ONE, COEF_ONE));
      send_point(COORD_MAX, '0, COORD_MIN, '0);
      send_point(COORD_MAX, 32'sd1, COORD_MIN, -32'sd1);
      send_point(COORD_MIN, '0, COORD_MAX, '0);
      send_point(COORD_MIN, -32'sd1, COORD_MAX, 32'sd1);
   endtask

   // writes to unmapped indexes must leave the matrix alone
   task automatic test_unmapped_index();
      settle();
      write_row(FIRST_UNUSED_IDX, '1);
      write_row(LAST_UNUSED_IDX, 64'hA5A5_5A5A_C3C3_3C3C);
      send_point(COORD_MAX, COORD_MIN, 32'sd12345, -32'sd6789);
      send_point(32'sd7, -32'sd7, 32'sd70000, -32'sd70000);
   endtask

   // random matrices, each followed by a burst of random points
   task automatic test_random_stream();
      for (int phase = 0; phase < PHASES; phase++) begin
         steady_flow = 1'b0;
         if (phase == 0)
            // back to identity with a full-range stream through it
            load_matrix(pack_row(COEF_ONE, '0, '0, '0), pack_row('0, COEF_ONE, '0, '0),
                        pack_row('0, '0, COEF_ONE, '0), pack_row('0, '0, '0, COEF_ONE));
         else
            load_matrix(rand_row(), rand_row(), rand_row(), rand_row());
         if ($urandom_range(0, 2) == 0)
            write_row(vt4x4_pkg::csr_idx_type'($urandom_range(FIRST_UNUSED_IDX,
                                                              LAST_UNUSED_IDX)),
                      rand_row());
         // every fourth phase runs at full rate on both sides
         steady_flow = (phase % 4 == 1);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            // mid-phase hold-off: sender waits out the whole pipe once
            if (phase == 6 && n == PHASE_WORDS / 2)
               drain_results();
            send_random_point();
         end
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.in_x  = '0;
      req_bus.in_y  = '0;
      req_bus.in_z  = '0;
      req_bus.in_w  = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data  = '0;
      // identity after reset
      matrix_rows[0] = pack_row(COEF_ONE, '0, '0, '0);
      matrix_rows[1] = pack_row('0, COEF_ONE, '0, '0);
      matrix_rows[2] = pack_row('0, '0, COEF_ONE, '0);
      matrix_rows[3] = pack_row('0, '0, '0, COEF_ONE);
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_identity();
      test_extreme_matrix();
      test_floor_rounding();
      test_saturation_edges();
      test_unmapped_index();
      test_random_stream();

      // let the last words drain, then watch for stray results
      drain_results();
      repeat (PIPE_LATENCY + 8) @(posedge clock);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: filelist.f
src/vt4x4_pkg.sv
src/vt4x4_if.sv
src/vt4x4_lane.sv
src/vt4x4_merge.sv
src/vertex_transform_4x4.sv
src/vt4x4_chk.sv
dv/tb.sv
